// ===== hdl/dbd_pkg.sv =====
// ============================================================================
// dbd_pkg
// Shared widths, constants, stage-control type and the month table for the
// day count between two calendar dates.
// ============================================================================
package dbd_pkg;

    // Largest year accepted; larger years clamp to it.
    localparam int unsigned MAX_YEAR = 9999;

    // Field widths of the input and output words.
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int OUT_W   = 22;

    // Width of a day number: enough for every clamped year plus a full year.
    localparam int N_W = $clog2(MAX_YEAR * 366 + 400);

    // Width that holds both a difference and the output ceiling.
    localparam int DIFF_W = (N_W > OUT_W) ? N_W : OUT_W;

    // Largest value the output field can show.
    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    // Division by 100 as a multiply by a reciprocal; exact for 14-bit values.
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 19;
    localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(5243);
    localparam int PROD_W = YEAR_W + RECIP_W;
    localparam int Q_W    = PROD_W - RECIP_SHIFT;

    // Calendar constants.
    localparam logic [YEAR_W-1:0]  YEAR_FIRST   = YEAR_W'(1);
    localparam logic [YEAR_W-1:0]  CENTURY      = YEAR_W'(100);
    localparam logic [MONTH_W-1:0] MONTH_JAN    = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_FEB    = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_DEC    = MONTH_W'(12);
    localparam logic [N_W-1:0]     DAYS_IN_YEAR = N_W'(365);

    // Days before a month, plus leap adjust and day of month, fit in this.
    localparam int DBM_W = 9;

    // Number of register stages from input to output register.
    localparam int PIPE_DEPTH = 5;

    // Advance enables for the four stages of the day-number pipeline.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } dbd_adv_t;

    // Days in the months before month m of a common year.
    function automatic logic [DBM_W-1:0] days_before(input logic [MONTH_W-1:0] m);
        logic [DBM_W-1:0] r;
        case (m)
            4'd1:    r = DBM_W'(0);
            4'd2:    r = DBM_W'(31);
            4'd3:    r = DBM_W'(59);
            4'd4:    r = DBM_W'(90);
            4'd5:    r = DBM_W'(120);
            4'd6:    r = DBM_W'(151);
            4'd7:    r = DBM_W'(181);
            4'd8:    r = DBM_W'(212);
            4'd9:    r = DBM_W'(243);
            4'd10:   r = DBM_W'(273);
            4'd11:   r = DBM_W'(304);
            4'd12:   r = DBM_W'(334);
            default: r = DBM_W'(0);
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/dbd_in_if.sv =====
// ============================================================================
// dbd_in_if
// Channel that carries one pair of dates per word.
// ============================================================================
interface dbd_in_if;

    logic                            valid;
    logic                            ready;
    logic [dbd_pkg::YEAR_W-1:0]      year_a;
    logic [dbd_pkg::MONTH_W-1:0]     month_a;
    logic [dbd_pkg::DAY_W-1:0]       day_a;
    logic [dbd_pkg::YEAR_W-1:0]      year_b;
    logic [dbd_pkg::MONTH_W-1:0]     month_b;
    logic [dbd_pkg::DAY_W-1:0]       day_b;

    modport source (
        output valid, year_a, month_a, day_a, year_b, month_b, day_b,
        input  ready
    );

    modport sink (
        input  valid, year_a, month_a, day_a, year_b, month_b, day_b,
        output ready
    );

endinterface

// ===== hdl/dbd_out_if.sv =====
// ============================================================================
// dbd_out_if
// Channel that carries one day count per word.
// ============================================================================
interface dbd_out_if;

    logic                        valid;
    logic                        ready;
    logic [dbd_pkg::OUT_W-1:0]   days_apart;

    modport source (
        output valid, days_apart,
        input  ready
    );

    modport sink (
        input  valid, days_apart,
        output ready
    );

endinterface

// ===== hdl/dbd_day_num.sv =====
// ============================================================================
// dbd_day_num
// Four-stage pipeline that turns one date into its day number:
// 365*(y-1) + leap days before y + days before the month + day of month.
// ============================================================================
module dbd_day_num (
    input  logic                          clk,
    input  dbd_pkg::dbd_adv_t             adv,
    input  logic [dbd_pkg::YEAR_W-1:0]    year,
    input  logic [dbd_pkg::MONTH_W-1:0]   month,
    input  logic [dbd_pkg::DAY_W-1:0]     day,
    output logic [dbd_pkg::N_W-1:0]       day_num
);

    // Stage 1: clamp, reciprocal products, month table.
    logic [dbd_pkg::YEAR_W-1:0]  y_next;
    logic [dbd_pkg::MONTH_W-1:0] m_next;
    logic [dbd_pkg::YEAR_W-1:0]  p_next;

    logic [dbd_pkg::YEAR_W-1:0]  s1_y_reg;
    logic [dbd_pkg::YEAR_W-1:0]  s1_p_reg;
    logic [dbd_pkg::PROD_W-1:0]  s1_yprod_reg;
    logic [dbd_pkg::PROD_W-1:0]  s1_pprod_reg;
    logic [dbd_pkg::DBM_W-1:0]   s1_dbm_reg;
    logic                        s1_late_reg;
    logic [dbd_pkg::DAY_W-1:0]   s1_day_reg;

    // Stage 2: quotients, leap test, 365 times the elapsed years.
    logic [dbd_pkg::Q_W-1:0]     qy;
    logic [dbd_pkg::Q_W-1:0]     qp;
    logic                        div4;
    logic                        div100;
    logic                        leap;

    logic [dbd_pkg::N_W-1:0]     s2_p365_reg;
    logic [dbd_pkg::N_W-1:0]     s2_p4_reg;
    logic [dbd_pkg::N_W-1:0]     s2_q100_reg;
    logic [dbd_pkg::N_W-1:0]     s2_q400_reg;
    logic [dbd_pkg::DBM_W-1:0]   s2_dbm_reg;
    logic                        s2_adj_reg;
    logic [dbd_pkg::DAY_W-1:0]   s2_day_reg;

    // Stage 3: year part and month part; stage 4: their sum.
    logic [dbd_pkg::N_W-1:0]     s3_year_reg;
    logic [dbd_pkg::DBM_W-1:0]   s3_month_reg;
    logic [dbd_pkg::N_W-1:0]     s4_n_reg;

    // Out-of-range years and months are pulled to the nearest legal value.
    always_comb
    begin
        if (year == '0)
        begin
            y_next = dbd_pkg::YEAR_FIRST;
        end
        else if (32'(year) > dbd_pkg::MAX_YEAR)
        begin
            y_next = dbd_pkg::YEAR_W'(dbd_pkg::MAX_YEAR);
        end
        else
        begin
            y_next = year;
        end

        if (month == '0)
        begin
            m_next = dbd_pkg::MONTH_JAN;
        end
        else if (month > dbd_pkg::MONTH_DEC)
        begin
            m_next = dbd_pkg::MONTH_DEC;
        end
        else
        begin
            m_next = month;
        end

        p_next = y_next - dbd_pkg::YEAR_FIRST;
    end

    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            s1_y_reg     <= y_next;
            s1_p_reg     <= p_next;
            s1_yprod_reg <= dbd_pkg::PROD_W'(y_next) * dbd_pkg::PROD_W'(dbd_pkg::RECIP_100);
            s1_pprod_reg <= dbd_pkg::PROD_W'(p_next) * dbd_pkg::PROD_W'(dbd_pkg::RECIP_100);
            s1_dbm_reg   <= dbd_pkg::days_before(m_next);
            s1_late_reg  <= (m_next > dbd_pkg::MONTH_FEB);
            s1_day_reg   <= day;
        end
    end

    // A year divisible by 400 is a multiple of 100 whose century count is
    // a multiple of four.
    always_comb
    begin
        qy     = s1_yprod_reg[dbd_pkg::PROD_W-1:dbd_pkg::RECIP_SHIFT];
        qp     = s1_pprod_reg[dbd_pkg::PROD_W-1:dbd_pkg::RECIP_SHIFT];
        div4   = (s1_y_reg[1:0] == 2'b00);
        div100 = (s1_y_reg == dbd_pkg::YEAR_W'(dbd_pkg::YEAR_W'(qy) * dbd_pkg::CENTURY));
        leap   = (div4 && !div100) || (div100 && (qy[1:0] == 2'b00));
    end

    always_ff @(posedge clk)
    begin
        if (adv.s2)
        begin
            s2_p365_reg <= dbd_pkg::N_W'(s1_p_reg) * dbd_pkg::DAYS_IN_YEAR;
            s2_p4_reg   <= dbd_pkg::N_W'(s1_p_reg >> 2);
            s2_q100_reg <= dbd_pkg::N_W'(qp);
            s2_q400_reg <= dbd_pkg::N_W'(qp >> 2);
            s2_dbm_reg  <= s1_dbm_reg;
            s2_adj_reg  <= s1_late_reg && leap;
            s2_day_reg  <= s1_day_reg;
        end
    end

    // Year part and month part are summed separately to keep each stage short.
    always_ff @(posedge clk)
    begin
        if (adv.s3)
        begin
            s3_year_reg  <= s2_p365_reg + s2_p4_reg - s2_q100_reg + s2_q400_reg;
            s3_month_reg <= s2_dbm_reg + dbd_pkg::DBM_W'(s2_adj_reg)
                            + dbd_pkg::DBM_W'(s2_day_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.s4)
        begin
            s4_n_reg <= s3_year_reg + dbd_pkg::N_W'(s3_month_reg);
        end
    end

    assign day_num = s4_n_reg;

endmodule

// ===== hdl/days_between_dates.sv =====
// ============================================================================
// days_between_dates
// Absolute number of days between two Gregorian dates, fully pipelined.
// ============================================================================
//
// Usage:
//   The dates channel takes one word per cycle while not stalled, holding
//   two dates (year, month, day each). The result channel returns one
//   word per input word, in order, holding the absolute day count between
//   the two dates; it is zero when the dates are equal.
//   On the way to a valid result, four stages build each date's day
//   number (clamp and reciprocal multiply, leap test and year multiply,
//   partial sums, final sum), and then the output register takes the
//   difference and saturates it.
//   Throughput is one word per cycle while the receiver does not stall; the
//   two dates run in parallel copies of the day-number pipeline.
//   Each stage carries its own valid bit and advances when it is empty or
//   the next stage advances, so bubbles are squeezed out. When the receiver
//   stalls, the pipeline fills and the dates channel drops ready once all
//   five stages hold a word; nothing is lost or repeated.
//   Reset clears all valid bits; no word is in flight afterward.
//
module days_between_dates (
    input  logic        clk,
    input  logic        rst_n,
    dbd_in_if.sink      dates,
    dbd_out_if.source   result
);

    localparam int LAST = dbd_pkg::PIPE_DEPTH - 1;

    logic [dbd_pkg::PIPE_DEPTH-1:0] valid_reg;
    logic [dbd_pkg::PIPE_DEPTH-1:0] en;
    dbd_pkg::dbd_adv_t              adv;

    logic [dbd_pkg::N_W-1:0]        num_a;
    logic [dbd_pkg::N_W-1:0]        num_b;
    logic [dbd_pkg::N_W-1:0]        diff;
    logic [dbd_pkg::OUT_W-1:0]      days_next;
    logic [dbd_pkg::OUT_W-1:0]      days_reg;

    // A stage advances when it is empty or its successor advances.
    always_comb
    begin
        en[LAST] = !valid_reg[LAST] || result.ready;
        for (int k = LAST - 1; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k + 1];
        end
        adv.s1 = en[0];
        adv.s2 = en[1];
        adv.s3 = en[2];
        adv.s4 = en[3];
    end

    assign dates.ready = en[0];

    // Valid bits move with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= dates.valid;
            end
            for (int k = 1; k <= LAST; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k - 1];
                end
            end
        end
    end

    // Day numbers of both dates.
    dbd_day_num u_num_a (
        .clk     (clk),
        .adv     (adv),
        .year    (dates.year_a),
        .month   (dates.month_a),
        .day     (dates.day_a),
        .day_num (num_a)
    );

    dbd_day_num u_num_b (
        .clk     (clk),
        .adv     (adv),
        .year    (dates.year_b),
        .month   (dates.month_b),
        .day     (dates.day_b),
        .day_num (num_b)
    );

    // Magnitude of the difference, held at the output ceiling if too wide.
    always_comb
    begin
        diff = (num_a >= num_b) ? (num_a - num_b) : (num_b - num_a);
        if (dbd_pkg::DIFF_W'(diff) > dbd_pkg::DIFF_W'(dbd_pkg::OUT_MAX))
        begin
            days_next = dbd_pkg::OUT_MAX;
        end
        else
        begin
            days_next = dbd_pkg::OUT_W'(diff);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[LAST])
        begin
            days_reg <= days_next;
        end
    end

    assign result.valid      = valid_reg[LAST];
    assign result.days_apart = days_reg;

endmodule

// ===== hdl/dbd_checker.sv =====
// ============================================================================
// dbd_checker
// Port-level checks on the day-count block: output handshake, back-pressure
// and the number of words in flight.
// ============================================================================
module dbd_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [dbd_pkg::OUT_W-1:0]   days_apart
);

    localparam int CNT_W = $clog2(dbd_pkg::PIPE_DEPTH + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             in_take;
    logic             out_take;

    // Words accepted but not yet delivered.
    assign in_take  = in_valid && in_ready;
    assign out_take = out_valid && out_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (in_take && !out_take)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (!in_take && out_take)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // A stalled result stays valid.
    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its value.
    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(days_apart))
        else $error("result changed while stalled");

    // Input is refused only while the output is blocked.
    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input refused without output back-pressure");

    // A result appears only for a word in flight.
    a_no_spurious_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cnt_reg != '0)
        else $error("result without an accepted word");

    // No more words in flight than pipeline stages.
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) <= dbd_pkg::PIPE_DEPTH)
        else $error("more words in flight than stages");

endmodule

bind days_between_dates dbd_checker u_dbd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (dates.valid),
    .in_ready   (dates.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .days_apart (result.days_apart)
);
